// ----- rtl/knn_topk_weighted_vote_top_macros.svh -----
// Assertion macros for the nearest-neighbor vote block
`ifndef KNN_TOPK_WEIGHTED_VOTE_TOP_MACROS_SVH
`define KNN_TOPK_WEIGHTED_VOTE_TOP_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define KNN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define KNN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/knn_pkg.sv -----
// Shared types and constants of the nearest-neighbor vote block
`timescale 1ns / 1ps
package knn_pkg;
   localparam int MaxNeighbors = 32;
   localparam int NumClasses   = 10;
   localparam int DistW  = 16;
   localparam int LabelW = 4;
   localparam int LenW   = 6;
   localparam int BiasW  = 10;
   localparam int DenW   = 17;
   localparam int WeightW = 25;
   localparam int SumW    = 31;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_CLEAR   = 2'd1;
   localparam logic [1:0] OP_PREDICT = 2'd2;

   localparam logic CSR_LIST_LENGTH = 1'b0;
   localparam logic CSR_WEIGHT_BIAS = 1'b1;

   localparam logic [LenW-1:0]  LEN_RESET  = 6'd20;
   localparam logic [BiasW-1:0] BIAS_RESET = 10'd8;

   typedef struct packed {
      logic [1:0]        operation;
      logic [DistW-1:0]  cand_distance;
      logic [LabelW-1:0] cand_label;
      logic [LenW-1:0]   query_count;
   } req_type;

   typedef struct packed {
      logic [LabelW-1:0] predicted_class;
      logic              prediction_valid;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic do_insert;
      logic do_clear;
      logic vote_start;   // load query, clear sums
      logic vote_step;    // weigh next entry
      logic div_start;
      logic scan_start;
      logic scan_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic entries_done; // all query entries weighed
      logic div_done;
      logic scan_done;
      logic invalid;
   } sts_type;
endpackage

// ----- rtl/knn_div.sv -----
// Restoring divider for 2^24 / denominator, one quotient bit per cycle
`timescale 1ns / 1ps
module knn_div
   import knn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DenW-1:0]    den,
   output logic               done,
   output logic [WeightW-1:0] quot
);
   localparam int CntW = $clog2(WeightW + 1);
   logic [DenW:0]      rem_ff, rem_in;
   logic [WeightW-1:0] q_ff, q_in;
   logic [DenW-1:0]    den_ff, den_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               zero_ff, zero_in;
   logic [DenW:0]      trial;
   logic               bit_in;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; den_in = den_ff; cnt_in = cnt_ff;
      run_in = run_ff; zero_in = zero_ff;
      // dividend is a single one at bit 24: it enters on the first step
      bit_in = (cnt_ff == CntW'(WeightW));
      trial = {rem_ff[DenW-1:0], bit_in};
      if (start) begin
         rem_in = '0; q_in = '0; den_in = den; cnt_in = CntW'(WeightW);
         run_in = 1'b1; zero_in = (den == '0);
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[WeightW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[WeightW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in; zero_ff <= zero_in;
   end

   assign done = run_ff && (cnt_ff == CntW'(1));
   assign quot = zero_ff ? {1'b1, {(WeightW-1){1'b0}}} : q_in;
endmodule

// ----- rtl/knn_datapath.sv -----
// Sorted candidate list, class sums and winner scan
`timescale 1ns / 1ps
`include "knn_topk_weighted_vote_top_macros.svh"
module knn_datapath
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MaxNeighbors,
   parameter int NUM_CLASSES   = NumClasses
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req,
   input  logic             csr_valid,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  cmd_type          cmd,
   output sts_type          sts,
   output rsp_type          rsp_data
);
   localparam int IdxW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CntW = $clog2(MAX_NEIGHBORS + 1);
   localparam int ClsW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   logic [DistW-1:0]  dist_ff [MAX_NEIGHBORS];
   logic [LabelW-1:0] lab_ff  [MAX_NEIGHBORS];
   logic [CntW-1:0]   held_ff, held_in;
   logic [LenW-1:0]   len_ff;
   logic [BiasW-1:0]  bias_ff;
   logic [CntW-1:0]   eff_len;
   logic [MAX_NEIGHBORS-1:0] gt_vec;  // held entry strictly above candidate
   logic              full, drop;

   logic [SumW-1:0]   sum_ff [NUM_CLASSES];
   logic [CntW-1:0]   vidx_ff;
   logic [LenW-1:0]   qcnt_ff;
   logic              inval_ff;
   logic [ClsW-1:0]   scan_ff;
   logic [ClsW-1:0]   best_ff;
   logic [LabelW-1:0] cur_lab_ff;
   logic [WeightW-1:0] w;
   logic              div_done;
   logic [DenW-1:0]   den;

   always_comb begin
      if (len_ff == '0) eff_len = CntW'(1);
      else if ({1'b0, len_ff} > 7'(MAX_NEIGHBORS)) eff_len = CntW'(MAX_NEIGHBORS);
      else eff_len = CntW'(len_ff);
   end

   assign full = (held_ff >= eff_len);
   always_comb begin
      for (int i = 0; i < MAX_NEIGHBORS; i++)
         gt_vec[i] = (CntW'(i) < held_ff) && (dist_ff[i] > req.cand_distance);
      drop = full && !gt_vec[IdxW'(eff_len - 1'b1)];
   end

   always_comb begin
      held_in = held_ff;
      if (cmd.do_clear) held_in = '0;
      else if (cmd.do_insert && !full) held_in = held_ff + 1'b1;
      if (csr_valid && csr_index == CSR_LIST_LENGTH) begin
         if (held_ff > CntW'(csr_wdata[LenW-1:0]) && csr_wdata[LenW-1:0] != '0)
            held_in = ({1'b0, csr_wdata[LenW-1:0]} > 7'(MAX_NEIGHBORS)) ?
                      held_ff : CntW'(csr_wdata[LenW-1:0]);
         else if (csr_wdata[LenW-1:0] == '0 && held_ff > CntW'(1))
            held_in = CntW'(1);
      end
   end

   // shift-insert: each slot takes candidate, its left neighbor, or holds
   always_ff @(posedge clock) begin
      if (cmd.do_insert && !drop) begin
         for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            if (gt_vec[i] || (CntW'(i) == held_ff && !full)) begin
               if (i == 0 || !(gt_vec[(i == 0) ? 0 : i-1])) begin
                  dist_ff[i] <= req.cand_distance;
                  lab_ff[i]  <= req.cand_label;
               end else begin
                  dist_ff[i] <= dist_ff[(i == 0) ? 0 : i-1];
                  lab_ff[i]  <= lab_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0; len_ff <= LEN_RESET; bias_ff <= BIAS_RESET;
      end else begin
         held_ff <= held_in;
         if (csr_valid && csr_index == CSR_LIST_LENGTH) len_ff <= csr_wdata[LenW-1:0];
         if (csr_valid && csr_index == CSR_WEIGHT_BIAS) bias_ff <= csr_wdata[BiasW-1:0];
      end
   end

   assign den = DenW'(dist_ff[vidx_ff[IdxW-1:0]]) + DenW'(bias_ff);

   knn_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .den(den),
      .done(div_done), .quot(w)
   );

   always_ff @(posedge clock) begin
      if (cmd.vote_start) begin
         vidx_ff  <= '0;
         qcnt_ff  <= req.query_count;
         inval_ff <= (CntW'(req.query_count) > held_ff) ||
                     ({1'b0, req.query_count} > 7'(held_ff));
         for (int c = 0; c < NUM_CLASSES; c++) sum_ff[c] <= '0;
      end
      if (cmd.div_start) cur_lab_ff <= lab_ff[vidx_ff[IdxW-1:0]];
      if (cmd.vote_step) begin
         if ({1'b0, cur_lab_ff} < 5'(NUM_CLASSES))
            sum_ff[cur_lab_ff[ClsW-1:0]] <= sum_ff[cur_lab_ff[ClsW-1:0]] + SumW'(w);
         vidx_ff <= vidx_ff + 1'b1;
      end
      if (cmd.scan_start) begin
         scan_ff <= ClsW'(1); best_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (sum_ff[scan_ff] > sum_ff[best_ff]) best_ff <= scan_ff;
         scan_ff <= scan_ff + 1'b1;
      end
   end

   assign sts.entries_done = ({1'b0, vidx_ff} >= {1'b0, CntW'(qcnt_ff)}) ||
                             (7'(qcnt_ff) > 7'(MAX_NEIGHBORS));
   assign sts.div_done  = div_done;
   assign sts.scan_done = (scan_ff >= ClsW'(NUM_CLASSES - 1)) || (scan_ff == '0);
   assign sts.invalid   = inval_ff;
   assign rsp_data.predicted_class  = inval_ff ? '0 : LabelW'(best_ff);
   assign rsp_data.prediction_valid = !inval_ff;

   `KNN_ASSERT_IMPL(a_held_le_max, clock, reset, 1'b1,
      held_ff <= CntW'(MAX_NEIGHBORS), "held count above capacity")
   `KNN_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.do_clear && !csr_valid,
      held_ff == '0, "clear did not empty list")
   `KNN_ASSERT_IMPL(a_no_overlap, clock, reset, cmd.do_insert,
      !cmd.vote_step && !cmd.scan_step, "insert during vote")
endmodule

// ----- rtl/knn_ctrl.sv -----
// Sequencer for insert, clear and predict items
`timescale 1ns / 1ps
`include "knn_topk_weighted_vote_top_macros.svh"
module knn_ctrl
   import knn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] operation,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_DIV   = 6'b000100,
      S_SCAN0 = 6'b001000,
      S_SCAN  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.do_insert = (operation == OP_INSERT);
               cmd.do_clear  = (operation == OP_CLEAR);
               if (operation == OP_PREDICT) begin
                  cmd.vote_start = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (sts.invalid) state_in = S_DONE;
            else if (sts.entries_done) state_in = S_SCAN0;
            else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.vote_step = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_SCAN0: begin
            cmd.scan_start = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   `KNN_ASSERT_NEXT(a_predict_busy, clock, reset,
      start && !busy && operation == OP_PREDICT, busy, "predict did not start")
   `KNN_ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy,
      "no return to idle after result")
   `KNN_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff),
      "state not one-hot")
endmodule

// ----- rtl/knn_topk_weighted_vote_top.sv -----
// Top level of the nearest-neighbor candidate list and weighted vote
//  channel | direction | handshake
//  req_    | in        | start / busy
//  rsp_    | out       | rsp_valid strobe, no backpressure
//  csr_    | in        | csr_valid / csr_ready (always ready)
// Insert and clear finish without raising busy; the list shifts all slots in parallel.
// Predict holds busy through a check state and the serial divider for each
// voting entry, then through the scan states and the result state.
// A predict whose count exceeds the held entries goes from check to result.
// Reset is synchronous; it empties the list and restores register defaults.
// The result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps
module knn_topk_weighted_vote_top
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MaxNeighbors,
   parameter int NUM_CLASSES   = NumClasses
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   knn_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .operation(req_data.operation),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   knn_datapath #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .NUM_CLASSES(NUM_CLASSES)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .csr_valid(csr_valid),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule

// ----- tb/knn_vote_checker.sv -----
// Checker for the nearest-neighbor vote block: predicts and compares vote results
`timescale 1ns / 1ps
module knn_vote_checker
   import knn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          vote_count,
   output int          valid_votes
);
   logic [DistW-1:0]  near_dist [MaxNeighbors];
   logic [LabelW-1:0] near_label[MaxNeighbors];
   int unsigned       near_count;
   int unsigned       keep_raw;
   int unsigned       bias;
   rsp_type           vote_queue[$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      vote_count  = 0;
      valid_votes = 0;
   end

   function automatic int unsigned kept_length();
      if (keep_raw == 0) return 1;
      if (keep_raw > MaxNeighbors) return MaxNeighbors;
      return keep_raw;
   endfunction

   function automatic void place_candidate(logic [DistW-1:0] d, logic [LabelW-1:0] l);
      int unsigned len;
      int unsigned h;
      int unsigned p;
      int unsigned last;
      len = kept_length();
      h = (near_count > len) ? len : near_count;
      p = 0;
      // full list: drop anything not closer than the worst entry
      if (h >= len && d >= near_dist[len-1]) begin
         near_count = h;
         return;
      end
      while (p < h && near_dist[p] <= d) p++;
      last = (h < len) ? h : len - 1;
      for (int unsigned k = last; k > p; k--) begin
         near_dist[k]  = near_dist[k-1];
         near_label[k] = near_label[k-1];
      end
      near_dist[p]  = d;
      near_label[p] = l;
      near_count = (h < len) ? h + 1 : h;
   endfunction

   function automatic rsp_type weigh_vote(int unsigned n);
      logic [31:0] sums[NumClasses];
      logic [16:0] den;
      logic [31:0] w;
      int unsigned best;
      rsp_type r;
      r = '0;
      if (n > near_count) return r;
      for (int c = 0; c < NumClasses; c++) sums[c] = '0;
      for (int unsigned i = 0; i < n && i < MaxNeighbors; i++) begin
         den = {1'b0, near_dist[i]} + 17'(bias);
         w = (den == 0) ? 32'd16777216 : 32'd16777216 / {15'd0, den};
         if (near_label[i] < NumClasses) sums[near_label[i]] += w;
      end
      best = 0;
      for (int c = 1; c < NumClasses; c++)
         if (sums[c] > sums[best]) best = c;
      r.predicted_class  = best[LabelW-1:0];
      r.prediction_valid = 1'b1;
      return r;
   endfunction

   task automatic note_mismatch(string what, int want, int got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         near_count = 0;
         keep_raw   = LEN_RESET;
         bias       = BIAS_RESET;
         for (int i = 0; i < MaxNeighbors; i++) begin
            near_dist[i]  = '0;
            near_label[i] = '0;
         end
         vote_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (vote_queue.size() == 0) begin
               note_mismatch("unexpected result, class", -1, rsp_data.predicted_class);
            end else begin
               want = vote_queue.pop_front();
               vote_count++;
               if (rsp_data.prediction_valid) valid_votes++;
               if (rsp_data.predicted_class !== want.predicted_class)
                  note_mismatch("predicted_class", want.predicted_class,
                                rsp_data.predicted_class);
               if (rsp_data.prediction_valid !== want.prediction_valid)
                  note_mismatch("prediction_valid", want.prediction_valid,
                                rsp_data.prediction_valid);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LIST_LENGTH) begin
               keep_raw = csr_wdata[LenW-1:0];
               if (near_count > kept_length()) near_count = kept_length();
            end else begin
               bias = csr_wdata[BiasW-1:0];
            end
         end
         if (start && !busy) begin
            case (req_data.operation)
               OP_INSERT:  place_candidate(req_data.cand_distance, req_data.cand_label);
               OP_CLEAR:   near_count = 0;
               OP_PREDICT: vote_queue.push_back(weigh_vote(req_data.query_count));
               default: ;  // unused operation: ignore
            endcase
         end
      end
      pending = vote_queue.size();
   end
endmodule

// ----- tb/knn_topk_weighted_vote_top_test.sv -----
// Testbench top for the nearest-neighbor vote block: stimulus and verdict
`timescale 1ns / 1ps
module knn_topk_weighted_vote_top_test;
   import knn_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_LIST_LENGTH;
   logic [15:0] csr_wdata = '0;
   logic        req_taken = 1'b0;
   logic        csr_taken = 1'b0;
   int          fail_count, pending, vote_count, valid_votes;
   int          items_sent = 0;
   int          gap_pct = 0;

   always #5 clock = ~clock;

   knn_topk_weighted_vote_top uut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   knn_vote_checker vote_check (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .pending, .vote_count, .valid_votes
   );

   always @(posedge clock) begin
      req_taken <= start && !busy && !reset;
      csr_taken <= csr_valid && csr_ready && !reset;
   end

   // send one item; start stays high into the next item unless a gap is drawn
   task automatic send_item(logic [1:0] op, logic [15:0] d, logic [3:0] l, logic [5:0] n);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start = 1'b1;
      req_data.operation     = op;
      req_data.cand_distance = d;
      req_data.cand_label    = l;
      req_data.query_count   = n;
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   // hold until every vote is back and the block has gone quiet
   task automatic wait_idle();
      start = 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(negedge clock); while (!csr_taken);
      csr_valid = 1'b0;
   endtask

   task automatic random_item();
      int unsigned pick;
      logic [15:0] d;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: d = 16'($urandom_range(0, 15));
         1: d = 16'($urandom_range(0, 2047));
         2: d = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
         default: d = 16'($urandom_range(0, 65535));
      endcase
      if (pick < 72)
         send_item(OP_INSERT, d, ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9)), '0);
      else if (pick < 90)
         send_item(OP_PREDICT, 16'($urandom), 4'($urandom),
                   ($urandom_range(5) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 10)));
      else if (pick < 95)
         send_item(OP_CLEAR, 16'($urandom), 4'($urandom), 6'($urandom));
      else
         send_item(2'd3, 16'($urandom), 4'($urandom), 6'($urandom));
   endtask

   initial begin
      int phase_pct[4] = '{0, 55, 0, 22};
      logic [15:0] phase_len[4] = '{16'd1, 16'd32, 16'd0, 16'd63};
      logic [15:0] phase_bias[4] = '{16'd1023, 16'd0, 16'd300, 16'd5};
      repeat (2) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: zero divisor, ties, out-of-range labels and counts, empty list
      write_reg(CSR_WEIGHT_BIAS, 16'd0);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd1);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd0);
      send_item(OP_INSERT, 16'd0, 4'd3, 6'd0);
      send_item(OP_INSERT, 16'hFFFF, 4'd15, 6'd0);
      send_item(OP_INSERT, 16'd5, 4'd9, 6'd0);
      send_item(OP_INSERT, 16'd5, 4'd10, 6'd0);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd4);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd5);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd63);
      send_item(2'd3, 16'hFFFF, 4'hF, 6'h3F);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd2);
      send_item(OP_INSERT, 16'd4, 4'd1, 6'd0);
      send_item(OP_INSERT, 16'd4, 4'd2, 6'd0);
      wait_idle();
      // shrink the list below the held count
      write_reg(CSR_LIST_LENGTH, 16'd2);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd3);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd2);
      send_item(OP_INSERT, 16'd1, 4'd7, 6'd0);
      send_item(OP_INSERT, 16'hFFFF, 4'd1, 6'd0);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd2);
      send_item(OP_CLEAR, 16'd0, 4'd0, 6'd0);
      send_item(OP_PREDICT, 16'd0, 4'd0, 6'd1);

      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         write_reg(CSR_LIST_LENGTH, phase_len[ph]);
         write_reg(CSR_WEIGHT_BIAS, phase_bias[ph]);
         gap_pct = phase_pct[ph];
         for (int i = 0; i < 125; i++) random_item();
      end
      wait_idle();
      write_reg(CSR_LIST_LENGTH, 16'd20);
      write_reg(CSR_WEIGHT_BIAS, 16'd8);
      gap_pct = 0;
      for (int i = 0; i < 40; i++) random_item();

      wait_idle();
      repeat (50) @(negedge clock);
      $display("Sent %0d items across five register settings and idle mixes;", items_sent);
      $display("checked %0d votes, %0d of them valid.", vote_count, valid_votes);
      if (fail_count == 0 && pending == 0)
         $display("knn_topk_weighted_vote_top_test OK");
      else
         $display("knn_topk_weighted_vote_top_test NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("knn_topk_weighted_vote_top_test NOT OK");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/knn_pkg.sv
rtl/knn_div.sv
rtl/knn_datapath.sv
rtl/knn_ctrl.sv
rtl/knn_topk_weighted_vote_top.sv
tb/knn_vote_checker.sv
tb/knn_topk_weighted_vote_top_test.sv
